// ===== src/alarm_clock_button_controller_defines.svh =====
// Assertion macros shared by the alarm clock button controller RTL.
`ifndef ALARM_CLOCK_BUTTON_CONTROLLER_DEFINES_SVH
`define ALARM_CLOCK_BUTTON_CONTROLLER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define ACBC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ACBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/acbc_pkg.sv =====
// Shared types and constants of the alarm clock button controller.
package acbc_pkg;

   localparam int FRAME_COUNT_DEFAULT = 16;

   localparam logic [4:0] HOUR_RESET   = 5'd12;
   localparam logic [4:0] HOUR_LAST    = 5'd23;
   localparam logic [5:0] MINUTE_LAST  = 6'd59;
   localparam logic [3:0] REPEAT_RESET = 4'd2;

   typedef enum logic [3:0] {
      EV_TICK          = 4'd0,
      EV_LIGHT_UP      = 4'd1,
      EV_LIGHT_LONG    = 4'd2,
      EV_ALARM_UP      = 4'd3,
      EV_ALARM_LONG    = 4'd4,
      EV_ALARM_LONG_UP = 4'd5,
      EV_MINUTE_POLL   = 4'd6,
      EV_MELODY_DONE   = 4'd7,
      EV_TIMEOUT       = 4'd8,
      EV_ACTIVATE      = 4'd9,
      EV_RESIGN        = 4'd10
   } event_code_type;

   typedef enum logic [1:0] {
      TICK_NONE = 2'd0,
      TICK_1HZ  = 2'd1,
      TICK_4HZ  = 2'd2,
      TICK_8HZ  = 2'd3
   } tick_rate_type;

   typedef enum logic [1:0] {
      FIELD_NONE   = 2'd0,
      FIELD_HOUR   = 2'd1,
      FIELD_MINUTE = 2'd2
   } field_sel_type;

   typedef struct packed {
      logic [3:0] func;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
   } event_item_type;

   typedef struct packed {
      logic [4:0] alarm_hour;
      logic [5:0] alarm_minute;
      logic       armed;
      logic [1:0] set_field;
      logic       fast_set;
      logic       ringing;
      logic [3:0] frame_index;
      logic [1:0] tick_request;
      logic       start_melody;
      logic       stop_melody;
      logic       leave_face;
      logic       fired;
   } result_type;

endpackage

// ===== src/alarm_clock_button_controller.sv =====
// Top level of the alarm clock button controller: handshake pipeline and config.
//
//   channel  direction  ports                      payload
//   req      in         req_valid / req_ready      func, now_hour, now_minute
//   rsp      out        rsp_valid / rsp_ready      alarm state and requests
//   csr      in         csr_write_enable           melody_repeat_count
//
// One event per cycle while the result is taken, through an input register,
// then the event decode and state update, which load the result register.
// The state registers advance only when an event enters the result register.
// A stalled result holds both stages; the input takes a new event whenever its
// stage empties in the same cycle. Synchronous reset, no clearing pass.
`include "alarm_clock_button_controller_defines.svh"

module alarm_clock_button_controller import acbc_pkg::*; #(
   parameter int FRAME_COUNT = FRAME_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_func,
   input  logic [4:0] req_now_hour,
   input  logic [5:0] req_now_minute,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_alarm_hour,
   output logic [5:0] rsp_alarm_minute,
   output logic       rsp_armed,
   output logic [1:0] rsp_set_field,
   output logic       rsp_fast_set,
   output logic       rsp_ringing,
   output logic [3:0] rsp_frame_index,
   output logic [1:0] rsp_tick_request,
   output logic       rsp_start_melody,
   output logic       rsp_stop_melody,
   output logic       rsp_leave_face,
   output logic       rsp_fired,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data
);

   logic           in_valid_ff;
   event_item_type in_ev_ff;
   logic           out_valid_ff;
   result_type     out_ff;
   result_type     result;
   logic           advance;
   logic [3:0]     repeat_ff;

   // Move the held event forward when the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Hold the melody repeat count
   always_ff @(posedge clock) begin
      if (reset) repeat_ff <= REPEAT_RESET;
      else if (csr_write_enable) repeat_ff <= csr_write_data;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ev_ff.func       <= req_func;
         in_ev_ff.now_hour   <= req_now_hour;
         in_ev_ff.now_minute <= req_now_minute;
      end
   end

   acbc_core #(
      .FRAME_COUNT(FRAME_COUNT)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .ev          (in_ev_ff),
      .repeat_count(repeat_ff),
      .result      (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= result;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_alarm_hour   = out_ff.alarm_hour;
   assign rsp_alarm_minute = out_ff.alarm_minute;
   assign rsp_armed        = out_ff.armed;
   assign rsp_set_field    = out_ff.set_field;
   assign rsp_fast_set     = out_ff.fast_set;
   assign rsp_ringing      = out_ff.ringing;
   assign rsp_frame_index  = out_ff.frame_index;
   assign rsp_tick_request = out_ff.tick_request;
   assign rsp_start_melody = out_ff.start_melody;
   assign rsp_stop_melody  = out_ff.stop_melody;
   assign rsp_leave_face   = out_ff.leave_face;
   assign rsp_fired        = out_ff.fired;

   // A fired alarm rings, starts the melody and asks for four Hz
   `ACBC_ASSERT_SAME(a_fire_rings, rsp_valid && rsp_fired, rsp_ringing && rsp_start_melody && (rsp_tick_request == TICK_4HZ), "fired result without ringing setup")
   // A stopped melody leaves the alarm silent
   `ACBC_ASSERT_SAME(a_stop_silent, rsp_valid && rsp_stop_melody, !rsp_ringing && !rsp_start_melody, "stop request while still ringing")
   // The field selector never reaches its unused code
   `ACBC_ASSERT_SAME(a_field_range, rsp_valid, rsp_set_field != 2'd3, "set field out of range")
   // A held event stays in the input stage while the result stalls
   `ACBC_ASSERT_NEXT(a_in_hold, in_valid_ff && !advance, in_valid_ff && $stable(in_ev_ff), "held event lost")

endmodule

// ===== src/acbc_core.sv =====
// Controller state and the per-event update logic.
module acbc_core import acbc_pkg::*; #(
   parameter int FRAME_COUNT = FRAME_COUNT_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  event_item_type ev,
   input  logic [3:0]     repeat_count,
   output result_type     result
);

   localparam logic [3:0] FRAME_LAST = 4'(FRAME_COUNT - 1);

   logic [4:0] hour_ff, hour_in;
   logic [5:0] minute_ff, minute_in;
   logic       armed_ff, armed_in;
   logic [1:0] field_ff, field_in;
   logic       fast_ff, fast_in;
   logic       ringing_ff, ringing_in;
   logic [3:0] frame_ff, frame_in;
   logic [3:0] loops_ff, loops_in;
   logic [5:0] guard_minute_ff, guard_minute_in;
   logic       guard_valid_ff, guard_valid_in;
   logic       linked_ff, linked_in;

   logic [1:0] tick_req;
   logic       start_req, stop_req, leave_req, fired_req;
   logic [4:0] hour_bump;
   logic [5:0] minute_bump;
   logic [1:0] field_inc;
   logic [3:0] loops_inc;

   // Wrapping increments of the field being set
   assign hour_bump   = (hour_ff == HOUR_LAST) ? 5'd0 : hour_ff + 5'd1;
   assign minute_bump = (minute_ff == MINUTE_LAST) ? 6'd0 : minute_ff + 6'd1;
   assign field_inc   = field_ff + 2'd1;
   assign loops_inc   = loops_ff + 4'd1;

   // Decode the event and form the next state and requests
   always_comb begin
      hour_in         = hour_ff;
      minute_in       = minute_ff;
      armed_in        = armed_ff;
      field_in        = field_ff;
      fast_in         = fast_ff;
      ringing_in      = ringing_ff;
      frame_in        = frame_ff;
      loops_in        = loops_ff;
      guard_minute_in = guard_minute_ff;
      guard_valid_in  = guard_valid_ff;
      linked_in       = linked_ff;
      tick_req        = TICK_NONE;
      start_req       = 1'b0;
      stop_req        = 1'b0;
      leave_req       = 1'b0;
      fired_req       = 1'b0;
      unique case (ev.func)
         EV_TICK: begin
            if (ringing_ff) begin
               frame_in = (frame_ff == FRAME_LAST) ? 4'd0 : frame_ff + 4'd1;
            end else if (fast_ff) begin
               if (field_ff == FIELD_HOUR) hour_in = hour_bump;
               else if (field_ff == FIELD_MINUTE) minute_in = minute_bump;
            end
         end
         EV_LIGHT_UP: begin
            if (ringing_ff) begin
               stop_req   = 1'b1;
               ringing_in = 1'b0;
               loops_in   = 4'd0;
               tick_req   = TICK_1HZ;
            end else if (field_ff == FIELD_NONE) begin
               field_in = FIELD_HOUR;
               tick_req = TICK_4HZ;
            end else if (field_inc > FIELD_MINUTE) begin
               field_in = FIELD_NONE;
               tick_req = TICK_1HZ;
            end else begin
               field_in = field_inc;
            end
         end
         EV_LIGHT_LONG: begin
            if (field_ff != FIELD_NONE) begin
               field_in = FIELD_NONE;
               fast_in  = 1'b0;
               tick_req = TICK_1HZ;
            end else begin
               field_in = FIELD_HOUR;
               tick_req = TICK_4HZ;
            end
         end
         EV_ALARM_UP: begin
            if (ringing_ff) begin
               stop_req   = 1'b1;
               ringing_in = 1'b0;
               loops_in   = 4'd0;
               tick_req   = TICK_1HZ;
            end else if (field_ff != FIELD_NONE) begin
               fast_in  = 1'b0;
               armed_in = 1'b1;
               if (field_ff == FIELD_HOUR) hour_in = hour_bump;
               else if (field_ff == FIELD_MINUTE) minute_in = minute_bump;
            end
         end
         EV_ALARM_LONG: begin
            if (field_ff == FIELD_NONE && !ringing_ff) begin
               armed_in = !armed_ff;
            end else if (field_ff != FIELD_NONE) begin
               fast_in  = 1'b1;
               tick_req = TICK_8HZ;
            end
         end
         EV_ALARM_LONG_UP: begin
            if (fast_ff) begin
               fast_in  = 1'b0;
               tick_req = TICK_4HZ;
            end
         end
         EV_MINUTE_POLL: begin
            if (armed_ff && !(guard_valid_ff && guard_minute_ff == ev.now_minute)) begin
               if (hour_ff == ev.now_hour && minute_ff == ev.now_minute) begin
                  guard_minute_in = ev.now_minute;
                  guard_valid_in  = 1'b1;
                  linked_in       = 1'b1;
                  ringing_in      = 1'b1;
                  frame_in        = 4'd0;
                  loops_in        = 4'd0;
                  tick_req        = TICK_4HZ;
                  start_req       = 1'b1;
                  fired_req       = 1'b1;
               end else begin
                  guard_valid_in = 1'b0;
               end
            end
         end
         EV_MELODY_DONE: begin
            if (linked_ff && ringing_ff) begin
               if (loops_inc < repeat_count) begin
                  loops_in  = loops_inc;
                  start_req = 1'b1;
               end else begin
                  ringing_in = 1'b0;
                  loops_in   = 4'd0;
               end
            end
         end
         EV_TIMEOUT: begin
            leave_req = !ringing_ff;
         end
         EV_ACTIVATE: begin
            linked_in = 1'b1;
         end
         EV_RESIGN: begin
            field_in  = FIELD_NONE;
            fast_in   = 1'b0;
            linked_in = 1'b0;
            tick_req  = TICK_1HZ;
         end
         default: begin
         end
      endcase
   end

   // Report the state after the event with its requests
   always_comb begin
      result.alarm_hour   = hour_in;
      result.alarm_minute = minute_in;
      result.armed        = armed_in;
      result.set_field    = field_in;
      result.fast_set     = fast_in;
      result.ringing      = ringing_in;
      result.frame_index  = frame_in;
      result.tick_request = tick_req;
      result.start_melody = start_req;
      result.stop_melody  = stop_req;
      result.leave_face   = leave_req;
      result.fired        = fired_req;
   end

   // Commit the new state when a transaction moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff         <= HOUR_RESET;
         minute_ff       <= 6'd0;
         armed_ff        <= 1'b0;
         field_ff        <= FIELD_NONE;
         fast_ff         <= 1'b0;
         ringing_ff      <= 1'b0;
         frame_ff        <= 4'd0;
         loops_ff        <= 4'd0;
         guard_minute_ff <= 6'd0;
         guard_valid_ff  <= 1'b0;
         linked_ff       <= 1'b0;
      end else if (step) begin
         hour_ff         <= hour_in;
         minute_ff       <= minute_in;
         armed_ff        <= armed_in;
         field_ff        <= field_in;
         fast_ff         <= fast_in;
         ringing_ff      <= ringing_in;
         frame_ff        <= frame_in;
         loops_ff        <= loops_in;
         guard_minute_ff <= guard_minute_in;
         guard_valid_ff  <= guard_valid_in;
         linked_ff       <= linked_in;
      end
   end

endmodule
